// ===== rtl/core/assert_macros.svh =====
// Assertion macros of the modular inverse unit, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mi_pkg.sv =====
// Shared command and status types of the modular inverse unit.
`default_nettype none

package mi_pkg;

    // Commands from the controller to the datapath; at most one is high per cycle.
    typedef struct packed {
        logic load;      // take a new operand pair
        logic start;     // prepare the divider for one Euclid round
        logic div_step;  // one restoring division step with product accumulation
        logic acc_step;  // last product accumulation step of a round
        logic update;    // shift remainders and cofactors along
        logic finish;    // normalise the cofactor and capture the result
    } mi_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r1_zero;   // current divisor is zero, Euclid has ended
    } mi_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mi_datapath.sv =====
// Datapath: remainder and cofactor registers, shift-subtract divider, result register.
`default_nettype none

module mi_datapath #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire mi_pkg::mi_cmd_t      cmd,
    output mi_pkg::mi_stat_t          stat,
    input  wire logic [WORD_BITS-1:0] in_value,
    input  wire logic [WORD_BITS-1:0] in_modulus,
    output logic      [WORD_BITS-1:0] inverse,
    output logic                      no_inverse
);
    import mi_pkg::*;

    // Signed cofactors need two bits beyond the word: products stay within twice the modulus.
    localparam int SW = WORD_BITS + 2;

    logic [WORD_BITS-1:0]    r0_reg, r0_next;
    logic [WORD_BITS-1:0]    r1_reg, r1_next;
    logic [WORD_BITS-1:0]    m_reg, m_next;
    logic                    mzero_reg, mzero_next;
    logic signed [SW-1:0]    t0_reg, t0_next;
    logic signed [SW-1:0]    t1_reg, t1_next;
    logic signed [SW-1:0]    acc_reg, acc_next;
    logic [WORD_BITS-1:0]    rem_reg, rem_next;
    logic [WORD_BITS-1:0]    dq_reg, dq_next;
    logic                    qbit_reg, qbit_next;
    logic [WORD_BITS-1:0]    inv_reg, inv_next;
    logic                    flag_reg, flag_next;

    logic [WORD_BITS:0]      shifted;
    logic [WORD_BITS+1:0]    diff;
    logic                    ge;
    logic signed [SW-1:0]    acc_upd;
    logic signed [SW-1:0]    t_norm;
    logic                    flag_now;

    // Divider trial subtraction: shift in the next dividend bit and compare with the divisor.
    assign shifted = {rem_reg, dq_reg[WORD_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r1_reg};
    assign ge      = ~diff[WORD_BITS+1];

    // Product q*t1 is built MSB first from the registered quotient bit of the previous divider step.
    assign acc_upd = $signed({acc_reg[SW-2:0], 1'b0}) + (qbit_reg ? t1_reg : SW'(0));

    // Final normalisation of the cofactor into 0..modulus-1.
    assign t_norm   = t0_reg[SW-1] ? (t0_reg + $signed({2'b00, m_reg})) : t0_reg;
    assign flag_now = mzero_reg || (r0_reg != WORD_BITS'(1));

    always_comb
    begin
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        m_next     = m_reg;
        mzero_next = mzero_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        qbit_next  = qbit_reg;
        inv_next   = inv_reg;
        flag_next  = flag_reg;
        if (cmd.load)
        begin
            // The first round from (value, modulus) reduces the value modulo the modulus.
            r0_next    = in_value;
            r1_next    = in_modulus;
            m_next     = in_modulus;
            mzero_next = (in_modulus == '0);
            t0_next    = SW'(1);
            t1_next    = '0;
        end
        if (cmd.start)
        begin
            rem_next  = '0;
            dq_next   = r0_reg;
            acc_next  = '0;
            qbit_next = 1'b0;
        end
        if (cmd.div_step)
        begin
            rem_next  = ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
            dq_next   = {dq_reg[WORD_BITS-2:0], ge};
            qbit_next = ge;
            acc_next  = acc_upd;
        end
        if (cmd.acc_step)
        begin
            acc_next  = acc_upd;
            qbit_next = 1'b0;
        end
        if (cmd.update)
        begin
            r0_next = r1_reg;
            r1_next = rem_reg;
            t0_next = t1_reg;
            t1_next = t0_reg - acc_reg;
        end
        if (cmd.finish)
        begin
            flag_next = flag_now;
            inv_next  = flag_now ? '0 : t_norm[WORD_BITS-1:0];
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        m_reg     <= m_next;
        mzero_reg <= mzero_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        qbit_reg  <= qbit_next;
        inv_reg   <= inv_next;
        flag_reg  <= flag_next;
    end

    assign stat.r1_zero = (r1_reg == '0);
    assign inverse      = inv_reg;
    assign no_inverse   = flag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mi_controller.sv =====
// Controller: sequences Euclid rounds and owns the input and output handshakes.
`default_nettype none

module mi_controller #(
    parameter int WORD_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mi_pkg::mi_cmd_t       cmd,
    input  wire mi_pkg::mi_stat_t stat
);
    import mi_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ACCF  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    // The result register may be refilled once its beat has gone or is going now.
    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.r1_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(WORD_BITS - 1))
                begin
                    state_next = ST_ACCF;
                end
            end
            ST_ACCF:
            begin
                cmd.acc_step = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid rises with a captured result and falls when its beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/modular_inverse_unit.sv =====
// Top level of the modular inverse unit: extended Euclid with a shift-subtract divider.
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata: value, modulus (low bits first), zero padded to bytes
//  m_*       out        tdata: inverse, zero padded to bytes; tuser: no_inverse
//
// An item runs through R Euclid rounds, including the initial reduction of the value
// (R is at most about 47 for 32-bit words). Each round is one quotient bit per cycle
// in the divider.
// Reset clears the controller and the output valid; no clearing pass is needed.
// A new item is taken as soon as the previous one has been moved to the output
// register, which holds its beat until m_tready; the next result waits for it.
`default_nettype none

module modular_inverse_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // value [WORD_BITS-1:0], modulus [2*WORD_BITS-1:WORD_BITS], zero padding above
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // inverse [WORD_BITS-1:0], zero padding above
    output logic      [((WORD_BITS+7)/8)*8-1:0]        m_tdata,
    // no_inverse [0]
    output logic                                       m_tuser
);
    import mi_pkg::*;

    localparam int OUT_W = ((WORD_BITS + 7) / 8) * 8;

    mi_cmd_t              cmd;
    mi_stat_t             stat;
    logic [WORD_BITS-1:0] inverse;
    logic                 no_inverse;

    // Sequencing of the Euclid rounds.
    mi_controller #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Remainders, cofactors and the divider.
    mi_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .in_value   (s_tdata[WORD_BITS-1:0]),
        .in_modulus (s_tdata[2*WORD_BITS-1:WORD_BITS]),
        .inverse    (inverse),
        .no_inverse (no_inverse)
    );

    assign m_tdata = OUT_W'(inverse);
    assign m_tuser = no_inverse;

    // Checks on the sequencing and on the result.
`include "assert_macros.svh"

    `CHK_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `CHK_IMPL(a_flag_zero_inverse, clk, rst_n, m_tvalid && m_tuser, inverse == '0)

endmodule

`default_nettype wire
